[hw/rtl/bsfp_pkg.sv]
// ----------------------------------------------------------------------------
// bsfp_pkg
// Shared widths, sizes and codes for the base status frame parser.
// ----------------------------------------------------------------------------
package bsfp_pkg;

   // Frame geometry
   localparam int FRAME_LEN   = 27;                  // payload bytes per frame
   localparam int SUM_LEN     = 26;                  // bytes covered by the checksum
   localparam int DECODE_LEN  = 15;                  // payload bytes 0..14 carry fields
   localparam int POS_W       = $clog2(FRAME_LEN);

   // Field widths
   localparam int BYTE_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int MASK_W      = 4;
   localparam int VEL_W       = 8;
   localparam int IMU_W       = 17;

   // Offsets removed from raw values, and the reset value of the sync byte
   localparam logic [BYTE_W-1:0] VEL_OFFSET = 8'd128;
   localparam logic [IMU_W-1:0]  IMU_OFFSET = 17'd10000;
   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hFE;

   // Frame status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_VALID     = 2'd0,
      STATUS_OVERCUR   = 2'd1,
      STATUS_CHK_ERROR = 2'd2
   } status_type;

   typedef logic [BYTE_W-1:0]         byte_type;
   typedef logic signed [VEL_W-1:0]   vel_type;
   typedef logic signed [IMU_W-1:0]   imu_type;

endpackage

[hw/rtl/bsfp_if.sv]
// ----------------------------------------------------------------------------
// bsfp_if
// Valid/ready channels of the base status frame parser: received bytes in,
// decoded frame reports out.
// ----------------------------------------------------------------------------
interface bsfp_req_if;
   import bsfp_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsfp_rsp_if;
   import bsfp_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] frame_status;
   logic [MASK_W-1:0]   wheel_fault_mask;
   vel_type             vel_x;
   vel_type             vel_y;
   vel_type             vel_yaw;
   imu_type             accel_x;
   imu_type             accel_y;
   imu_type             accel_z;
   imu_type             gyro_x;
   imu_type             gyro_y;
   imu_type             gyro_z;

   modport source (output valid, output frame_status, output wheel_fault_mask,
                   output vel_x, output vel_y, output vel_yaw,
                   output accel_x, output accel_y, output accel_z,
                   output gyro_x, output gyro_y, output gyro_z, input ready);
   modport sink   (input valid, input frame_status, input wheel_fault_mask,
                   input vel_x, input vel_y, input vel_yaw,
                   input accel_x, input accel_y, input accel_z,
                   input gyro_x, input gyro_y, input gyro_z, output ready);
endinterface

[hw/rtl/base_status_frame_parser.sv]
// ----------------------------------------------------------------------------
// base_status_frame_parser
// Hunts two sync bytes, stores the 27-byte payload in a frame memory and
// decodes one status report per frame from a read-back sweep of that memory.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  req     | in  | req.valid/req.ready  | rx_byte
//  rsp     | out | rsp.valid/rsp.ready  | frame_status, wheel_fault_mask,
//          |     |                      | vel_x/y/yaw, accel_x/y/z, gyro_x/y/z
//  csr     | in  | csr_we               | csr_wdata (sync byte)
//
//  One byte is taken per cycle while req.ready is high. A report follows the
//  last payload byte through a sweep over the frame memory's read port, the
//  registered read data, the wait and done states and one output register.
//  The last payload byte of a frame waits while the previous sweep or its
//  report is still pending; all other bytes are taken while rsp stalls.
//  Synchronous reset returns to sync hunting and sets the sync byte to 0xFE;
//  the frame memory is not cleared, every entry read is written first.
// ----------------------------------------------------------------------------
module base_status_frame_parser
   import bsfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   bsfp_req_if.sink          req,
   bsfp_rsp_if.source        rsp,
   input  logic              csr_we,
   input  logic [BYTE_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      PH_HUNT1 = 3'b001,
      PH_HUNT2 = 3'b010,
      PH_DATA  = 3'b100
   } phase_type;

   typedef enum logic [3:0] {
      SW_IDLE = 4'b0001,
      SW_READ = 4'b0010,
      SW_WAIT = 4'b0100,
      SW_DONE = 4'b1000
   } sweep_type;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
   localparam logic [POS_W-1:0] LAST_RD  = POS_W'(DECODE_LEN - 1);

   // Registers
   byte_type            sync_ff;
   phase_type           phase_ff, phase_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   byte_type            sum_ff, sum_in;
   logic                chk_ok_ff;
   sweep_type           sw_ff, sw_in;
   logic [POS_W-1:0]    rd_addr_ff;
   logic                rd_vld_ff;
   byte_type            rd_data_ff;
   byte_type            line_ff [DECODE_LEN];
   byte_type            mem [FRAME_LEN];

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [MASK_W-1:0]   mask_ff;
   vel_type             vel_ff [3];
   imu_type             imu_ff [6];

   logic accept, in_data, frame_last, wr_en, rd_en, load_out;
   logic [BYTE_W+1:0] wheel_sum;
   logic              is_overcur;
   logic [MASK_W-1:0] mask_now;

   assign accept     = req.valid && req.ready;
   assign in_data    = (phase_ff == PH_DATA);
   assign frame_last = in_data && (pos_ff == LAST_POS);
   assign wr_en      = accept && in_data;
   assign rd_en      = (sw_ff == SW_READ);
   assign load_out   = (sw_ff == SW_DONE) && (!rsp_valid_ff || rsp.ready);

   // Hold the closing byte while the previous frame is still being reported
   assign req.ready  = !frame_last || (sw_ff == SW_IDLE);

   // Sync register
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_RESET;
      end else if (csr_we) begin
         sync_ff <= csr_wdata;
      end
   end

   // Sync hunt and payload position
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      if (accept) begin
         case (phase_ff)
            PH_HUNT2: begin
               phase_in = (req.rx_byte == sync_ff) ? PH_DATA : PH_HUNT1;
               pos_in   = '0;
               sum_in   = '0;
            end
            PH_DATA: begin
               if (frame_last) begin
                  phase_in = PH_HUNT1;
                  pos_in   = '0;
                  sum_in   = '0;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
                  sum_in = sum_ff + req.rx_byte;
               end
            end
            default: begin
               phase_in = (req.rx_byte == sync_ff) ? PH_HUNT2 : PH_HUNT1;
               pos_in   = '0;
               sum_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         pos_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
      end
   end

   // Capture the checksum verdict with the closing byte
   always_ff @(posedge clock) begin
      if (accept && frame_last) begin
         chk_ok_ff <= (sum_ff == req.rx_byte);
      end
   end

   // Frame memory: write as bytes arrive, read back during the sweep.
   // The sweep reads entry k before the next frame, which needs two sync bytes
   // first, can write it, so the ports never touch the same entry in one cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= req.rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   // Sweep sequencer
   always_comb begin
      sw_in = sw_ff;
      case (sw_ff)
         SW_IDLE: if (accept && frame_last) sw_in = SW_READ;
         SW_READ: if (rd_addr_ff == LAST_RD) sw_in = SW_WAIT;
         SW_WAIT: sw_in = SW_DONE;
         SW_DONE: if (load_out) sw_in = SW_IDLE;
         default: sw_in = SW_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff      <= SW_IDLE;
         rd_addr_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         sw_ff      <= sw_in;
         rd_vld_ff  <= rd_en;
         if (rd_en) begin
            rd_addr_ff <= (rd_addr_ff == LAST_RD) ? '0 : rd_addr_ff + POS_W'(1);
         end
      end
   end

   // Shift read-back bytes into the decode line; byte k ends at tap k
   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         for (int i = 0; i < DECODE_LEN - 1; i++) begin
            line_ff[i] <= line_ff[i+1];
         end
         line_ff[DECODE_LEN-1] <= rd_data_ff;
      end
   end

   // Overcurrent test and wheel mask
   assign wheel_sum  = (BYTE_W+2)'(line_ff[0]) + (BYTE_W+2)'(line_ff[1])
                     + (BYTE_W+2)'(line_ff[2]) + (BYTE_W+2)'(line_ff[3]);
   assign is_overcur = (wheel_sum == (BYTE_W+2)'(line_ff[4]));

   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         mask_now[i] = (line_ff[i] == byte_type'(1));
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         mask_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            vel_ff[i] <= '0;
         end
         for (int i = 0; i < 6; i++) begin
            imu_ff[i] <= '0;
         end
         if (is_overcur) begin
            status_ff <= STATUS_OVERCUR;
            mask_ff   <= mask_now;
         end else if (!chk_ok_ff) begin
            status_ff <= STATUS_CHK_ERROR;
         end else begin
            status_ff <= STATUS_VALID;
            for (int i = 0; i < 3; i++) begin
               vel_ff[i] <= vel_type'(line_ff[i] - VEL_OFFSET);
            end
            for (int i = 0; i < 6; i++) begin
               imu_ff[i] <= imu_type'({1'b0, line_ff[2*i+4], line_ff[2*i+3]} - IMU_OFFSET);
            end
         end
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.frame_status     = status_ff;
   assign rsp.wheel_fault_mask = mask_ff;
   assign rsp.vel_x            = vel_ff[0];
   assign rsp.vel_y            = vel_ff[1];
   assign rsp.vel_yaw          = vel_ff[2];
   assign rsp.accel_x          = imu_ff[0];
   assign rsp.accel_y          = imu_ff[1];
   assign rsp.accel_z          = imu_ff[2];
   assign rsp.gyro_x           = imu_ff[3];
   assign rsp.gyro_y           = imu_ff[4];
   assign rsp.gyro_z           = imu_ff[5];

   // Checks
   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (pos_ff != rd_addr_ff))
      else $error("frame memory read and write hit the same entry");

   a_close_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && frame_last) |-> (sw_ff == SW_IDLE))
      else $error("frame closed while previous sweep busy");

   a_report_from_sweep: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(sw_ff == SW_DONE))
      else $error("report raised without a finished sweep");

   a_sweep_start: assert property (@(posedge clock) disable iff (reset)
      (sw_ff == SW_IDLE && sw_in == SW_READ) |=> (rd_addr_ff == '0))
      else $error("sweep did not start at entry zero");

endmodule
